[sv/brm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brm_pkg: shared types and constants of the banked ROM mapper
// Item layouts, decode constants, change and mirroring codes, and the
// request and response records of the shared remainder unit.
// ----------------------------------------------------------------------------
package brm_pkg;

	// Input item: a bus write or a scanline tick.
	typedef struct packed {
		logic        kind;
		logic [15:0] addr;
		logic [7:0]  data;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [1:0] change;
		logic [2:0] slot;
		logic [7:0] page;
		logic [1:0] mirror_mode;
		logic       irq_request;
	} out_item_t;

	// Item kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// Change codes.
	localparam logic [1:0] CHG_NONE   = 2'd0;
	localparam logic [1:0] CHG_PRG    = 2'd1;
	localparam logic [1:0] CHG_CHR    = 2'd2;
	localparam logic [1:0] CHG_MIRROR = 2'd3;

	// Mirroring modes.
	localparam logic [1:0] MIR_HORZ   = 2'd0;
	localparam logic [1:0] MIR_VERT   = 2'd1;
	localparam logic [1:0] MIR_SINGLE = 2'd2;
	localparam logic [1:0] MIR_SEL_3  = 2'd3;

	// Configuration register indexes.
	localparam logic REG_PRG_UNITS = 1'b0;
	localparam logic REG_CHR_UNITS = 1'b1;

	// Address decode.
	localparam logic [15:0] DEC_MASK      = 16'hF003;
	localparam logic [15:0] ADDR_RELOAD   = 16'hF000;
	localparam logic [15:0] ADDR_ENABLE   = 16'hF001;
	localparam logic [15:0] ADDR_MIRROR   = 16'hF002;
	localparam logic [3:0]  TOP_PRG_FIRST = 4'h8;
	localparam logic [3:0]  TOP_PRG_LAST  = 4'h9;
	localparam logic [3:0]  TOP_CHR_FIRST = 4'hA;
	localparam logic [3:0]  TOP_CHR_LAST  = 4'hD;
	localparam logic [3:0]  TOP_LATCH     = 4'hE;

	// Bank register file: three program entries, then eight pattern entries.
	localparam int          BANK_COUNT    = 11;
	localparam int          BANK_IDX_W    = $clog2(BANK_COUNT);
	localparam logic [BANK_IDX_W-1:0] BANK_CHR_BASE = BANK_IDX_W'(3);

	// Interrupt counter.
	localparam int          CNT_W       = 24;
	localparam int          CYCLE_SHIFT = 8;
	localparam logic [15:0] LINE_STEP   = 16'd29098;

	// Remainder unit: 8-bit dividend, divisor up to eight times 255.
	localparam int DVD_W = 8;
	localparam int DIV_W = 11;
	localparam int STEP_W = $clog2(DVD_W);

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] rem;
	} div_rsp_t;

	// Configuration register values.
	typedef struct packed {
		logic [7:0] prg_rom_units;
		logic [7:0] chr_rom_units;
	} cfg_t;

endpackage

[sv/banked_rom_mapper_with_line_irq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_rom_mapper_with_line_irq: banked ROM mapper with scanline interrupt
// Decodes bus writes into bank, latch, reload, enable and mirroring updates,
// reports bank pages through a shared remainder unit, and counts scanline
// ticks down toward an interrupt.
//
//   Channel   Handshake             Payload     Direction
//   in        in_valid / in_ready   in_item     write or tick toward the block
//   out       out_valid / out_ready out_item    one result per item
//   config    psel / penable        paddr etc.  APB register access
//
// A bank write reaches a valid result after eight one-bit steps of the
// remainder unit; the wait state then picks up the remainder, and the
// hand-off state passes the result to the output register.
// Other writes and all ticks pass straight to the hand-off state on acceptance.
// One item is in flight at a time; in_ready is high only while idle, so the
// next item can be accepted in the cycle after the hand-off.
// A stalled result holds in the output register; the next item is still
// accepted and worked, and only its hand-off waits for the register to free.
// Reset clears the bank registers, latch, counter and enable at once.
// ----------------------------------------------------------------------------
module banked_rom_mapper_with_line_irq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  brm_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output brm_pkg::out_item_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import brm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]            state_q;
	logic [7:0]            bank_q [BANK_COUNT];
	logic [15:0]           latch_q;
	logic [CNT_W-1:0]      counter_q;
	logic                  irq_en_q;
	out_item_t             res_q;
	out_item_t             out_item_q;
	logic                  out_valid_q;

	cfg_t                  cfg;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	logic                  accept;
	logic                  out_free;
	logic [15:0]           dec;
	logic [3:0]            top;
	logic [3:0]            top_off;
	logic [1:0]            low;
	logic                  is_prg;
	logic                  is_chr;
	logic [2:0]            slot;
	logic [BANK_IDX_W-1:0] reg_idx;
	logic [7:0]            old_val;
	logic [7:0]            new_val;
	logic [31:0]           reload_wide;
	logic [CNT_W-1:0]      reload_val;
	out_item_t             res_d;

	// Configuration registers.
	brm_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Shared remainder unit for page numbers.
	brm_modulo u_modulo (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Address decode and the new bank register value.
	always_comb begin
		dec     = in_item.addr & DEC_MASK;
		top     = dec[15:12];
		low     = dec[1:0];
		top_off = top - TOP_CHR_FIRST;
		is_prg  = (top == TOP_PRG_FIRST) || (top == TOP_PRG_LAST && !low[1]);
		is_chr  = top inside {[TOP_CHR_FIRST:TOP_CHR_LAST]};
		if (is_prg) begin
			slot    = {1'b0, top[0], low[1]};
			reg_idx = BANK_IDX_W'(slot);
		end else begin
			slot    = {top_off[1:0], low[1]};
			reg_idx = BANK_IDX_W'(slot) + BANK_CHR_BASE;
		end
		old_val = bank_q[reg_idx];
		if (low[0]) begin
			new_val = {in_item.data[3:0], old_val[3:0]};
		end else begin
			new_val = {old_val[7:4], in_item.data[3:0]};
		end
		reload_wide = 32'(latch_q) << CYCLE_SHIFT;
		reload_val  = (|reload_wide[31:CNT_W]) ? '1 : reload_wide[CNT_W-1:0];
	end

	// Result fields known at acceptance; the page follows from the unit.
	always_comb begin
		res_d = '0;
		if (in_item.kind == KIND_TICK) begin
			res_d.irq_request = irq_en_q && (counter_q <= CNT_W'(LINE_STEP));
		end else if (is_prg) begin
			res_d.change = CHG_PRG;
			res_d.slot   = slot;
		end else if (is_chr) begin
			res_d.change = CHG_CHR;
			res_d.slot   = slot;
		end else if (dec == ADDR_MIRROR) begin
			res_d.change      = CHG_MIRROR;
			res_d.mirror_mode = (in_item.data[1:0] == MIR_SEL_3) ? MIR_SINGLE
				: in_item.data[1:0];
		end
	end

	// Remainder unit request: a bank write starts it with the new value.
	always_comb begin
		div_req.start    = accept && (in_item.kind == KIND_WRITE) && (is_prg || is_chr);
		div_req.dividend = new_val;
		div_req.divisor  = is_prg ? {2'b00, cfg.prg_rom_units, 1'b0}
			: {cfg.chr_rom_units, 3'b000};
	end

	// Mapper state updates at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANK_COUNT; i++) begin
				bank_q[i] <= '0;
			end
			latch_q   <= '0;
			counter_q <= '0;
			irq_en_q  <= 1'b0;
		end else if (accept) begin
			if (in_item.kind == KIND_TICK) begin
				if (irq_en_q) begin
					if (counter_q <= CNT_W'(LINE_STEP)) begin
						counter_q <= '0;
						irq_en_q  <= 1'b0;
					end else begin
						counter_q <= counter_q - CNT_W'(LINE_STEP);
					end
				end
			end else if (is_prg || is_chr) begin
				bank_q[reg_idx] <= new_val;
			end else if (top == TOP_LATCH) begin
				latch_q[{low, 2'b00} +: 4] <= in_item.data[3:0];
			end else if (dec == ADDR_RELOAD) begin
				counter_q <= reload_val;
			end else if (dec == ADDR_ENABLE) begin
				irq_en_q <= in_item.data[0];
			end
		end
	end

	// Sequencer: idle, waiting on the remainder unit, handing off the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= div_req.start ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Pending result.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			res_q.page <= div_rsp.rem;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_item_q <= res_q;
		end
	end

	// An interrupt result never carries a bank or mirroring change.
	a_irq_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.irq_request |-> out_item_q.change == CHG_NONE)
		else $error("interrupt reported together with a change");

	// Slot and page stay zero unless a bank changed.
	a_page_only_bank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_item_q.change == CHG_NONE || out_item_q.change == CHG_MIRROR)
		|-> out_item_q.slot == '0 && out_item_q.page == '0)
		else $error("slot or page reported without a bank change");

	// The remainder unit finishes only while the sequencer waits on it.
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("remainder result outside of the wait state");

	// Raising the interrupt leaves it disabled.
	a_irq_disables: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && res_q.irq_request |-> !irq_en_q)
		else $error("interrupt enable still set after raising the interrupt");

endmodule

[sv/brm_modulo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brm_modulo: iterative remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder.
// A zero divisor gives a remainder of zero.
// ----------------------------------------------------------------------------
module brm_modulo (
	input  logic              clk,
	input  logic              arst_n,
	input  brm_pkg::div_req_t req,
	output brm_pkg::div_rsp_t rsp
);
	import brm_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic             zero_q;
	logic [STEP_W-1:0] step_q;
	logic [DVD_W-1:0] dividend_q;
	logic [DIV_W-1:0] divisor_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   diff;
	logic             fits;

	// One shift-compare-subtract step.
	always_comb begin
		shifted = {rem_q, dividend_q[DVD_W-1]};
		diff    = shifted - {1'b0, divisor_q};
		fits    = shifted >= {1'b0, divisor_q};
	end

	// Step sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and remainder registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dividend_q <= req.dividend;
			divisor_q  <= req.divisor;
			zero_q     <= (req.divisor == '0);
			rem_q      <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[DVD_W-2:0], 1'b0};
			rem_q      <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = zero_q ? '0 : rem_q[DVD_W-1:0];

	// The remainder is below the divisor once the steps are over.
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !zero_q |-> rem_q < divisor_q)
		else $error("remainder not below divisor");

	// A finished result follows the last step directly.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("done without a preceding step");

	// No new start while stepping.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start)
		else $error("remainder unit restarted while busy");

endmodule

[sv/brm_apb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brm_apb: configuration register port
// Holds the program and pattern ROM sizes, written and read over APB.
// ----------------------------------------------------------------------------
module brm_apb (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output brm_pkg::cfg_t cfg
);
	import brm_pkg::*;

	logic [7:0] prg_units_q;
	logic [7:0] chr_units_q;
	logic       wr_en;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_units_q <= 8'd1;
			chr_units_q <= 8'd0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_PRG_UNITS: prg_units_q <= pwdata[7:0];
				REG_CHR_UNITS: chr_units_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read data.
	always_comb begin
		case (reg_sel)
			REG_PRG_UNITS: prdata = {24'd0, prg_units_q};
			REG_CHR_UNITS: prdata = {24'd0, chr_units_q};
			default:       prdata = '0;
		endcase
	end

	assign cfg.prg_rom_units = prg_units_q;
	assign cfg.chr_rom_units = chr_units_q;

endmodule
